// File: hdl/fpvp_pkg.sv
// shared package for the flash page vector patcher
// op, result kind and register index codes, defaults and the control/status structs
// no dependencies
package fpvp_pkg;

  // input operation codes
  localparam logic [1:0] OP_SET_ADDR = 2'd0;
  localparam logic [1:0] OP_DATA     = 2'd1;
  localparam logic [1:0] OP_ERASE    = 2'd2;
  localparam logic [1:0] OP_FLUSH    = 2'd3;

  // result kind codes
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_PAGE  = 2'd2;
  localparam logic [1:0] KIND_ERASE = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOADER_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_VEC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USB_VEC     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USB_SKIP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OSC_CAL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_MASK   = 3'd5;

  // register reset values
  localparam logic [15:0] RST_LOADER_BASE = 16'h0000;
  localparam logic [4:0]  RST_RESET_VEC   = 5'd0;
  localparam logic [4:0]  RST_USB_VEC     = 5'd1;
  localparam logic [2:0]  RST_USB_SKIP    = 3'd0;
  localparam logic [7:0]  RST_OSC_CAL     = 8'd0;
  localparam logic [14:0] RST_WORD_MASK   = 15'd4095;

  // default geometry
  localparam int unsigned DEF_PAGE_BYTES   = 64;
  localparam int unsigned DEF_VECTOR_BYTES = 2;

  // instruction encodings and word constants
  localparam logic [15:0] RJMP_BASE  = 16'hC000;
  localparam logic [15:0] RJMP_FIELD = 16'h0FFF;
  localparam logic [15:0] RJMP_SIGN  = 16'h0800;
  localparam logic [15:0] SIGN_FILL  = 16'hF000;
  localparam logic [15:0] JMP_WORD   = 16'h940C;
  localparam logic [15:0] ERASED     = 16'hFFFF;

  typedef struct packed {
    logic       load;       // input transfer, latch item and save vector targets
    logic       set_ptr;    // load pointer and page offset from start address
    logic       clear_ptr;  // pointer back to zero
    logic       put;        // advance pointer by one word
    logic       emit;       // load output register
    logic [1:0] kind;
    logic       last;
    logic       pad;        // fill word is the erased pattern
  } fpvp_cmd_t;

  typedef struct packed {
    logic drop;           // data word at or beyond the loader entry
    logic wp_zero;
    logic off_zero;
    logic off_next_zero;  // page offset after one more word is zero
    logic out_free;
  } fpvp_status_t;

endpackage

// File: hdl/fpvp_ctrl.sv
// controller state machine for the flash page vector patcher
// sequences clear, fill, page write and erase results; depends on fpvp_pkg
module fpvp_ctrl import fpvp_pkg::*; #(
  parameter int unsigned PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [1:0]   in_op_i,
  input  fpvp_status_t status_i,
  output fpvp_cmd_t    cmd_o
);

  localparam int unsigned PAD_LIMIT = (PAGE_BYTES + 1) / 2;
  localparam int unsigned PCNT_W    = $clog2(PAD_LIMIT + 1);
  localparam logic [PCNT_W-1:0] PCNT_MAX = PCNT_W'(PAD_LIMIT);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETPTR = 3'd1;
  localparam logic [2:0] S_ERASE  = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_PAGE   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic              pad_q, pad_d;
  logic              clr_done_q, clr_done_d;
  logic [PCNT_W-1:0] pcnt_q, pcnt_d;
  logic [PCNT_W-1:0] pcnt_inc;

  assign in_stall_o = (state_q != S_IDLE);
  assign pcnt_inc   = pcnt_q + PCNT_W'(1);

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    pad_d      = pad_q;
    clr_done_d = clr_done_q;
    pcnt_d     = pcnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (in_op_i)
            OP_SET_ADDR: state_d = S_SETPTR;
            OP_DATA: begin
              if (status_i.drop) begin
                state_d = status_i.off_zero ? S_PAGE : S_IDLE;
              end else begin
                state_d    = S_PUT;
                pad_d      = 1'b0;
                clr_done_d = 1'b0;
              end
            end
            OP_ERASE: state_d = S_ERASE;
            OP_FLUSH: begin
              if (status_i.off_zero) begin
                state_d = S_PAGE;
              end else begin
                state_d    = S_PUT;
                pad_d      = 1'b1;
                clr_done_d = 1'b0;
                pcnt_d     = '0;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SETPTR: begin
        cmd_o.set_ptr = 1'b1;
        state_d       = S_IDLE;
      end
      S_ERASE: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.kind      = KIND_ERASE;
          cmd_o.clear_ptr = 1'b1;
          state_d         = S_PUT;
          pad_d           = 1'b1;
          clr_done_d      = 1'b0;
          pcnt_d          = '0;
        end
      end
      S_PUT: begin
        cmd_o.pad = pad_q;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.wp_zero && !clr_done_q) begin
            // buffer clear ahead of a fill at address zero
            cmd_o.kind = KIND_CLEAR;
            clr_done_d = 1'b1;
          end else begin
            cmd_o.kind = KIND_FILL;
            cmd_o.put  = 1'b1;
            cmd_o.last = !pad_q && !status_i.off_next_zero;
            clr_done_d = 1'b0;
            if (pad_q) begin
              pcnt_d = pcnt_inc;
              if (status_i.off_next_zero || (pcnt_inc >= PCNT_MAX)) begin
                state_d = S_PAGE;
              end
            end else begin
              state_d = status_i.off_next_zero ? S_PAGE : S_IDLE;
            end
          end
        end
      end
      S_PAGE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = KIND_PAGE;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pad_q      <= 1'b0;
      clr_done_q <= 1'b0;
      pcnt_q     <= '0;
    end else begin
      state_q    <= state_d;
      pad_q      <= pad_d;
      clr_done_q <= clr_done_d;
      pcnt_q     <= pcnt_d;
    end
  end

endmodule

// File: hdl/fpvp_dpath.sv
// datapath for the flash page vector patcher: registers, pointer, page offset,
// vector decode and patch, output register; depends on fpvp_pkg
module fpvp_dpath import fpvp_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = DEF_PAGE_BYTES,
  parameter int unsigned VECTOR_BYTES = DEF_VECTOR_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic [1:0]           in_op_i,
  input  logic [15:0]          in_start_address_i,
  input  logic [15:0]          in_data_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           out_kind_o,
  output logic [15:0]          out_flash_address_o,
  output logic [15:0]          out_fill_word_o,
  output logic                 out_last_o,
  input  fpvp_cmd_t            cmd_i,
  output fpvp_status_t         status_o
);

  localparam int unsigned OFF_W = $clog2(PAGE_BYTES);
  localparam bit          FOUR  = (VECTOR_BYTES == 4);
  localparam logic [15:0] PAGE16   = 16'(PAGE_BYTES);
  localparam logic [OFF_W:0] PAGE_C = (OFF_W + 1)'(PAGE_BYTES);
  localparam logic [15:0] RECIP    = 16'(65536 / PAGE_BYTES);
  localparam logic [OFF_W-1:0] OFF_FFFE = OFF_W'(65534 % PAGE_BYTES);
  localparam logic [OFF_W-1:0] OFF_FFFF = OFF_W'(65535 % PAGE_BYTES);
  localparam logic [15:0] VB16    = 16'(VECTOR_BYTES);
  localparam logic [15:0] TBL_LEN = 16'(2 * VECTOR_BYTES + 2);
  localparam logic [15:0] VW16    = 16'(VECTOR_BYTES / 2);

  // configuration registers
  logic [15:0] lb_q;
  logic [4:0]  rvi_q, uvi_q;
  logic [2:0]  skip_q;
  logic [7:0]  osc_q;
  logic [14:0] mask_q;

  // block state
  logic [15:0]      wp_q, wp_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [15:0]      sv0_q, sv0_d, sv1_q, sv1_d;

  // item and remainder pipeline
  logic [15:0] data_q;
  logic [15:0] start_q;
  logic [31:0] prod_q;

  // output register
  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic [15:0] out_addr_q, out_word_q;
  logic        out_last_q;

  logic [15:0] entry, rst_addr, usb_addr;
  logic        hit_rst, hit_rst_hi, hit_usb, hit_usb_hi;
  logic        data_ok;
  logic [15:0] qp, rem_est, rem_fix;
  logic [16:0] wp_inc;
  logic [OFF_W:0] off_sum, off_wrap_up;
  logic [OFF_W-1:0] off_inc, off_a;
  logic [15:0] page_addr;
  logic [15:0] word_in, patched;
  logic [15:0] lb_vb;

  function automatic logic [15:0] decode_jump(input logic [15:0] rj, input logic [15:0] loc,
                                              input logic [14:0] mask);
    logic [15:0] t;
    if (FOUR) begin
      if ((rj & RJMP_SIGN) != 16'd0) begin
        t = ((rj | SIGN_FILL) + loc + 16'd1) & {1'b0, mask};
      end else begin
        t = (rj & RJMP_FIELD) + loc + 16'd1;
      end
    end else begin
      t = rj + loc + 16'd1;
    end
    return t;
  endfunction

  function automatic logic [15:0] encode_jump(input logic [15:0] target, input logic [15:0] loc);
    logic [15:0] d;
    d = target - loc - 16'd1;
    return RJMP_BASE + (d & RJMP_FIELD);
  endfunction

  // derived addresses
  assign entry    = lb_q + TBL_LEN;
  assign rst_addr = {11'd0, rvi_q} * VB16;
  assign usb_addr = {11'd0, uvi_q} * VB16;
  assign lb_vb    = lb_q + VB16;

  // vector slot match on an incoming data word
  assign hit_rst    = (wp_q == rst_addr);
  assign hit_rst_hi = FOUR && (wp_q == rst_addr + 16'd2);
  assign hit_usb    = (wp_q == usb_addr);
  assign hit_usb_hi = FOUR && (wp_q == usb_addr + 16'd2);
  assign data_ok    = (in_data_word_i != 16'd0) && (in_data_word_i != ERASED);

  always_comb begin
    sv0_d = sv0_q;
    sv1_d = sv1_q;
    if (cmd_i.load && (in_op_i == OP_DATA)) begin
      if (hit_rst) begin
        sv0_d = decode_jump(in_data_word_i, {11'd0, rvi_q}, mask_q);
      end else if (hit_rst_hi) begin
        if (data_ok) sv0_d = in_data_word_i;
      end else if (hit_usb) begin
        sv1_d = decode_jump(in_data_word_i + {13'd0, skip_q}, {11'd0, uvi_q}, mask_q);
      end else if (hit_usb_hi) begin
        if (data_ok) sv1_d = in_data_word_i;
      end
    end
  end

  assign status_o.drop = !(hit_rst || hit_rst_hi || hit_usb || hit_usb_hi) && (wp_q >= entry);

  // start address modulo page size: reciprocal estimate, one correction
  assign qp      = prod_q[31:16] * PAGE16;
  assign rem_est = start_q - qp;
  assign rem_fix = (rem_est >= PAGE16) ? (rem_est - PAGE16) : rem_est;

  // page offset after one more word, with the 16-bit wrap of the pointer
  assign wp_inc  = {1'b0, wp_q} + 17'd2;
  assign off_sum = {1'b0, off_q} + (OFF_W + 1)'(2);
  always_comb begin
    if (wp_inc[16]) begin
      off_inc = {{(OFF_W - 1){1'b0}}, wp_inc[0]};
    end else if (off_sum >= PAGE_C) begin
      off_inc = OFF_W'(off_sum - PAGE_C);
    end else begin
      off_inc = off_sum[OFF_W-1:0];
    end
  end

  // offset of the word before the pointer, for the page write address
  assign off_wrap_up = {1'b0, off_q} + PAGE_C - (OFF_W + 1)'(2);
  always_comb begin
    if (wp_q == 16'd0) begin
      off_a = OFF_FFFE;
    end else if (wp_q == 16'd1) begin
      off_a = OFF_FFFF;
    end else if (off_q >= OFF_W'(2)) begin
      off_a = off_q - OFF_W'(2);
    end else begin
      off_a = off_wrap_up[OFF_W-1:0];
    end
  end
  assign page_addr = (wp_q - 16'd2) - 16'(off_a);

  // word patching at the vector slots and the table below the loader
  assign word_in = cmd_i.pad ? ERASED : data_q;
  always_comb begin
    if (wp_q == rst_addr) begin
      patched = encode_jump(entry >> 1, {11'd0, rvi_q} * VW16);
    end else if (wp_q == usb_addr) begin
      patched = encode_jump((entry + 16'd2) >> 1, {11'd0, uvi_q} * VW16);
    end else if (!FOUR && (wp_q == lb_q)) begin
      patched = encode_jump(sv0_q, lb_q >> 1);
    end else if (!FOUR && (wp_q == lb_vb)) begin
      patched = encode_jump(sv1_q, lb_vb >> 1);
    end else if (FOUR && (wp_q == lb_q)) begin
      patched = JMP_WORD;
    end else if (FOUR && (wp_q == lb_q + 16'd2)) begin
      patched = sv0_q;
    end else if (FOUR && (wp_q == lb_vb)) begin
      patched = JMP_WORD;
    end else if (FOUR && (wp_q == lb_vb + 16'd2)) begin
      patched = sv1_q + VB16;
    end else if (wp_q == lb_q + (VB16 << 1)) begin
      patched = {8'd0, osc_q};
    end else begin
      patched = word_in;
    end
  end

  // pointer and offset
  always_comb begin
    wp_d  = wp_q;
    off_d = off_q;
    if (cmd_i.set_ptr) begin
      wp_d  = start_q;
      off_d = rem_fix[OFF_W-1:0];
    end else if (cmd_i.clear_ptr) begin
      wp_d  = '0;
      off_d = '0;
    end else if (cmd_i.put) begin
      wp_d  = wp_inc[15:0];
      off_d = off_inc;
    end
  end

  assign status_o.wp_zero       = (wp_q == 16'd0);
  assign status_o.off_zero      = (off_q == '0);
  assign status_o.off_next_zero = (off_inc == '0);
  assign status_o.out_free      = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lb_q   <= RST_LOADER_BASE;
      rvi_q  <= RST_RESET_VEC;
      uvi_q  <= RST_USB_VEC;
      skip_q <= RST_USB_SKIP;
      osc_q  <= RST_OSC_CAL;
      mask_q <= RST_WORD_MASK;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LOADER_BASE: lb_q   <= cfg_wdata_i;
        CFG_RESET_VEC:   rvi_q  <= cfg_wdata_i[4:0];
        CFG_USB_VEC:     uvi_q  <= cfg_wdata_i[4:0];
        CFG_USB_SKIP:    skip_q <= cfg_wdata_i[2:0];
        CFG_OSC_CAL:     osc_q  <= cfg_wdata_i[7:0];
        CFG_WORD_MASK:   mask_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      off_q       <= '0;
      sv0_q       <= '0;
      sv1_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wp_q  <= wp_d;
      off_q <= off_d;
      sv0_q <= sv0_d;
      sv1_q <= sv1_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      data_q  <= in_data_word_i;
      start_q <= in_start_address_i;
      prod_q  <= {16'd0, in_start_address_i} * {16'd0, RECIP};
    end
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.kind;
      out_last_q <= cmd_i.last;
      case (cmd_i.kind)
        KIND_FILL: begin
          out_addr_q <= wp_q;
          out_word_q <= patched;
        end
        KIND_PAGE: begin
          out_addr_q <= page_addr;
          out_word_q <= '0;
        end
        default: begin
          out_addr_q <= '0;
          out_word_q <= '0;
        end
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_kind_o          = out_kind_q;
  assign out_flash_address_o = out_addr_q;
  assign out_fill_word_o     = out_word_q;
  assign out_last_o          = out_last_q;

endmodule

// File: hdl/flash_page_vector_patcher.sv
// flash page vector patcher: data word is a transfer then a fill result, only the transfer when dropped,
// plus a buffer clear at address zero or a page write; set address loads the pointer, no result
// erase and flush: the item is taken from idle, then one result per cycle, set by the single
// output register (stall on the result side holds the sequence)
// async active-low reset: registers to defaults, pointer and saved targets zero, no clear pass
module flash_page_vector_patcher import fpvp_pkg::*; #(
  parameter int unsigned PAGE_BYTES   = DEF_PAGE_BYTES,
  parameter int unsigned VECTOR_BYTES = DEF_VECTOR_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_wdata_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           in_op_i,
  input  logic [15:0]          in_start_address_i,
  input  logic [15:0]          in_data_word_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           out_kind_o,
  output logic [15:0]          out_flash_address_o,
  output logic [15:0]          out_fill_word_o,
  output logic                 out_last_o
);

  // controller drives commands, datapath returns status
  fpvp_cmd_t    cmd;
  fpvp_status_t status;

  // the controller takes a transfer only from idle; it walks the clear, fill,
  // erase and page-write results of one item through the output register
  fpvp_ctrl #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_op_i    (in_op_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // the datapath holds the configuration, write pointer with its page offset,
  // the saved vector targets, the word patch logic and the output register
  fpvp_dpath #(
    .PAGE_BYTES   (PAGE_BYTES),
    .VECTOR_BYTES (VECTOR_BYTES)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_op_i             (in_op_i),
    .in_start_address_i  (in_start_address_i),
    .in_data_word_i      (in_data_word_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_kind_o          (out_kind_o),
    .out_flash_address_o (out_flash_address_o),
    .out_fill_word_o     (out_fill_word_o),
    .out_last_o          (out_last_o),
    .cmd_i               (cmd),
    .status_o            (status)
  );

endmodule
